// ===== rtl/vni_pkg.sv =====
// Shared types, constants and header decode for the VVC NAL unit indexer.
package vni_pkg;

    localparam int OFFSET_BITS_DEF = 48;
    localparam int OUT_OFFSET_W    = 48;
    localparam int SIZE_W          = 32;
    localparam int TYPE_W          = 5;
    localparam int TID_W           = 3;
    localparam int LAYER_W         = 6;

    localparam logic [5:0]  LAYER_MASK   = 6'h3F;
    localparam logic [4:0]  TYPE_MISSING = 5'd31;
    localparam logic [4:0]  TYPE_VCL_MAX = 5'd11;
    localparam logic [4:0]  TYPE_IRAP_LO = 5'd7;
    localparam logic [4:0]  TYPE_IRAP_HI = 5'd9;
    localparam logic [4:0]  TYPE_SLC_HI  = 5'd10;
    localparam logic [4:0]  TYPE_RASL_HI = 5'd3;
    localparam logic [31:0] CNT_MAX      = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [OUT_OFFSET_W-1:0] unit_offset;
        logic [SIZE_W-1:0]       unit_size;
        logic [TYPE_W-1:0]       unit_type;
        logic [TID_W-1:0]        temporal_layer;
        logic [LAYER_W-1:0]      layer_number;
        logic                    is_vcl;
        logic                    is_slice;
        logic                    is_keyframe;
        logic                    last_of_run;
    } t_result;

    // Decode the two header bytes; offset, size and last flag are left zero.
    function automatic t_result decode_header(input logic hdr_ok, input logic [15:0] hdr);
        t_result r;
        logic [4:0] ty;
        r  = '0;
        ty = TYPE_MISSING;
        if (hdr_ok) begin
            ty               = hdr[7:3];
            r.layer_number   = hdr[13:8] & LAYER_MASK;
            r.temporal_layer = (hdr[2:0] != 3'd0) ? hdr[2:0] - 3'd1 : 3'd0;
        end
        r.unit_type   = ty;
        r.is_vcl      = (ty <= TYPE_VCL_MAX);
        r.is_slice    = (ty <= TYPE_RASL_HI) || (ty >= TYPE_IRAP_LO && ty <= TYPE_SLC_HI);
        r.is_keyframe = (ty >= TYPE_IRAP_LO) && (ty <= TYPE_IRAP_HI);
        return r;
    endfunction

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == CNT_MAX) ? v : v + 32'd1;
    endfunction

endpackage

// ===== rtl/vni_byte_if.sv =====
// Byte channel: one packet byte and its end-of-packet flag per item.
interface vni_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       packet_end;

    modport source (output valid, output data_byte, output packet_end, input ready);
    modport sink   (input valid, input data_byte, input packet_end, output ready);
endinterface

// ===== rtl/vni_unit_if.sv =====
// Unit channel: one indexed NAL unit record per item.
interface vni_unit_if
    import vni_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [OUT_OFFSET_W-1:0] unit_offset;
    logic [SIZE_W-1:0]       unit_size;
    logic [TYPE_W-1:0]       unit_type;
    logic [TID_W-1:0]        temporal_layer;
    logic [LAYER_W-1:0]      layer_number;
    logic                    is_vcl;
    logic                    is_slice;
    logic                    is_keyframe;
    logic                    last_of_run;

    modport source (output valid, output unit_offset, output unit_size, output unit_type,
                    output temporal_layer, output layer_number, output is_vcl,
                    output is_slice, output is_keyframe, output last_of_run, input ready);
    modport sink   (input valid, input unit_offset, input unit_size, input unit_type,
                    input temporal_layer, input layer_number, input is_vcl,
                    input is_slice, input is_keyframe, input last_of_run, output ready);
endinterface

// ===== rtl/vvc_nal_unit_indexer.sv =====
// VVC NAL unit indexer: Annex B / length-prefixed framing detection and unit records.
// Each unit record is written into the result queue when the byte that closes it is accepted.
// Throughput: one byte per cycle; a byte may close two units, whose records drain
// one per cycle while o_unit is ready, through a 4-entry result queue, and the byte
// port stalls while the queue holds more than two records.
// Reset (synchronous, active low) clears all packet state, the queue and the running offset.
module vvc_nal_unit_indexer
    import vni_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vni_byte_if.sink   i_byte,
    vni_unit_if.source o_unit
);

    localparam int SUM_W = ((OFFSET_BITS > SIZE_W + 1) ? OFFSET_BITS : SIZE_W + 1) + 1;

    typedef enum logic [1:0] {
        MODE_UNDECIDED,
        MODE_ANNEXB,
        MODE_PREFIXED,
        MODE_STOPPED
    } t_mode;

    function automatic logic [OFFSET_BITS-1:0] sat_add(input logic [OFFSET_BITS-1:0] a,
                                                       input logic [SIZE_W:0] b);
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        if (s[SUM_W-1:OFFSET_BITS] != '0) return '1;
        return s[OFFSET_BITS-1:0];
    endfunction

    // Packet state
    t_mode                  r_mode, n_mode;
    logic [31:0]            r_rb, n_rb;
    logic [2:0]             r_pp, n_pp;
    logic [31:0]            r_ubc, n_ubc;
    logic [31:0]            r_pl, n_pl;
    logic [15:0]            r_hb, n_hb;
    logic                   r_uo, n_uo;
    logic [2:0]             r_wf, n_wf;
    logic [1:0]             r_hf, n_hf;
    logic [OFFSET_BITS-1:0] r_ro, n_ro;

    // Result queue
    t_result    r_q [4];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_cnt, n_cnt;

    logic              accept, pop;
    logic              s0_v, s1_v, s0_hv, s1_hv;
    logic [SIZE_W:0]   s0_size, s1_size;
    logic [15:0]       s0_hb, s1_hb;
    logic [2:0]        code;
    logic [OFFSET_BITS-1:0] ro_mid;
    t_result           res0, res1;

    assign i_byte.ready = (r_cnt <= 3'd2);
    assign accept       = i_byte.valid && i_byte.ready;
    assign pop          = o_unit.valid && o_unit.ready;

    always_comb begin
        n_mode  = r_mode;
        n_rb    = r_rb;
        n_pp    = r_pp;
        n_ubc   = r_ubc;
        n_pl    = r_pl;
        n_hb    = r_hb;
        n_uo    = r_uo;
        n_wf    = r_wf;
        n_hf    = r_hf;
        s0_v    = 1'b0;
        s1_v    = 1'b0;
        s0_hv   = 1'b0;
        s1_hv   = 1'b0;
        s0_size = '0;
        s1_size = '0;
        s0_hb   = '0;
        s1_hb   = '0;
        code    = 3'd0;

        if (r_mode == MODE_ANNEXB) begin
            if (r_wf >= 3'd4 && r_rb == 32'h0000_0001) begin
                code = 3'd4;
            end else if (r_wf >= 3'd3 && r_rb[23:0] == 24'h00_0001) begin
                code = 3'd3;
            end
            if (code != 3'd0) begin
                // Close the unit in progress at the new start code
                if (r_uo) begin
                    s0_v    = 1'b1;
                    s0_size = (r_ubc > 32'(code)) ? {1'b0, r_ubc - 32'(code)} : '0;
                    s0_hv   = (r_hf >= 2'd2);
                    s0_hb   = r_hb;
                end
                n_uo  = 1'b1;
                n_ubc = 32'(code);
                n_hf  = 2'd0;
                n_hb  = '0;
                n_wf  = 3'd0;
            end
            if (n_uo) begin
                n_ubc = sat_inc(n_ubc);
                if (n_hf < 2'd2) begin
                    n_hb = {n_hb[7:0], i_byte.data_byte};
                    n_hf = n_hf + 2'd1;
                end
            end
        end else if (r_mode != MODE_STOPPED) begin
            n_ubc = sat_inc(r_ubc);
        end

        n_rb = {r_rb[23:0], i_byte.data_byte};
        if (n_wf < 3'd4) n_wf = n_wf + 3'd1;
        n_pp = (r_pp == 3'd4) ? r_pp : r_pp + 3'd1;

        if (r_mode == MODE_UNDECIDED) begin
            if (n_pp <= 3'd2) begin
                if (i_byte.data_byte != 8'd0) n_mode = MODE_PREFIXED;
            end else if (n_pp == 3'd3) begin
                if (i_byte.data_byte == 8'd1) begin
                    n_mode = MODE_ANNEXB;
                end else if (i_byte.data_byte != 8'd0) begin
                    n_mode = MODE_PREFIXED;
                end
            end else begin
                n_mode = (i_byte.data_byte == 8'd1) ? MODE_ANNEXB : MODE_PREFIXED;
            end
        end

        if (n_mode == MODE_PREFIXED) begin
            if (n_ubc == 32'd4) begin
                n_pl = n_rb;
                n_hf = 2'd0;
                n_hb = '0;
                if (n_rb == 32'd0) n_mode = MODE_STOPPED;
            end else if (n_ubc > 32'd4) begin
                if (n_hf < 2'd2) begin
                    n_hb = {n_hb[7:0], i_byte.data_byte};
                    n_hf = n_hf + 2'd1;
                end
                if ((n_ubc - 32'd4) == n_pl) begin
                    s0_v    = 1'b1;
                    s0_size = {1'b0, n_pl} + (SIZE_W + 1)'(4);
                    s0_hv   = (n_pl >= 32'd2) && (n_hf >= 2'd2);
                    s0_hb   = n_hb;
                    n_ubc   = '0;
                    n_hf    = 2'd0;
                    n_hb    = '0;
                end
            end
        end

        if (i_byte.packet_end) begin
            // Flush the open Annex B unit, then return to packet start
            if (n_mode == MODE_ANNEXB && n_uo) begin
                if (s0_v) begin
                    s1_v    = 1'b1;
                    s1_size = {1'b0, n_ubc};
                    s1_hv   = (n_hf >= 2'd2);
                    s1_hb   = n_hb;
                end else begin
                    s0_v    = 1'b1;
                    s0_size = {1'b0, n_ubc};
                    s0_hv   = (n_hf >= 2'd2);
                    s0_hb   = n_hb;
                end
            end
            n_mode = MODE_UNDECIDED;
            n_rb   = '0;
            n_pp   = '0;
            n_ubc  = '0;
            n_pl   = '0;
            n_hb   = '0;
            n_uo   = 1'b0;
            n_wf   = '0;
            n_hf   = '0;
        end
    end

    always_comb begin
        ro_mid = s0_v ? sat_add(r_ro, s0_size) : r_ro;
        n_ro   = s1_v ? sat_add(ro_mid, s1_size) : ro_mid;

        res0             = decode_header(s0_hv, s0_hb);
        res0.unit_offset = OUT_OFFSET_W'(r_ro);
        res0.unit_size   = s0_size[SIZE_W-1:0];
        res0.last_of_run = !s1_v;

        res1             = decode_header(s1_hv, s1_hb);
        res1.unit_offset = OUT_OFFSET_W'(ro_mid);
        res1.unit_size   = s1_size[SIZE_W-1:0];
        res1.last_of_run = 1'b1;

        n_cnt = r_cnt + (accept ? 3'(s0_v) + 3'(s1_v) : 3'd0) - 3'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_UNDECIDED;
            r_rb   <= '0;
            r_pp   <= '0;
            r_ubc  <= '0;
            r_pl   <= '0;
            r_hb   <= '0;
            r_uo   <= 1'b0;
            r_wf   <= '0;
            r_hf   <= '0;
            r_ro   <= '0;
            r_wr   <= '0;
            r_rd   <= '0;
            r_cnt  <= '0;
        end else begin
            if (accept) begin
                r_mode <= n_mode;
                r_rb   <= n_rb;
                r_pp   <= n_pp;
                r_ubc  <= n_ubc;
                r_pl   <= n_pl;
                r_hb   <= n_hb;
                r_uo   <= n_uo;
                r_wf   <= n_wf;
                r_hf   <= n_hf;
                r_ro   <= n_ro;
                r_wr   <= r_wr + {1'b0, s0_v} + {1'b0, s1_v};
            end
            if (pop) r_rd <= r_rd + 2'd1;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && s0_v) r_q[r_wr] <= res0;
        if (accept && s1_v) r_q[r_wr + 2'd1] <= res1;
    end

    assign o_unit.valid          = (r_cnt != 3'd0);
    assign o_unit.unit_offset    = r_q[r_rd].unit_offset;
    assign o_unit.unit_size      = r_q[r_rd].unit_size;
    assign o_unit.unit_type      = r_q[r_rd].unit_type;
    assign o_unit.temporal_layer = r_q[r_rd].temporal_layer;
    assign o_unit.layer_number   = r_q[r_rd].layer_number;
    assign o_unit.is_vcl         = r_q[r_rd].is_vcl;
    assign o_unit.is_slice       = r_q[r_rd].is_slice;
    assign o_unit.is_keyframe    = r_q[r_rd].is_keyframe;
    assign o_unit.last_of_run    = r_q[r_rd].last_of_run;

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("result queue overflow");

    a_packet_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_byte.packet_end |=> r_mode == MODE_UNDECIDED && !r_uo && r_ubc == '0)
        else $error("packet state not cleared at packet end");

    a_open_annexb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_uo |-> r_mode == MODE_ANNEXB)
        else $error("open unit outside Annex B framing");

    a_offset_mono: assert property (@(posedge i_clk)
        i_rst_n && $past(i_rst_n) |-> r_ro >= $past(r_ro))
        else $error("running offset decreased");

endmodule
